FILE: rtl/rwcw_pkg.sv
package rwcw_pkg;

    typedef enum logic [5:0] {
        PH_RIFF = 6'b000001,
        PH_LEN  = 6'b000010,
        PH_WAVE = 6'b000100,
        PH_HDR  = 6'b001000,
        PH_BODY = 6'b010000,
        PH_DONE = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        CK_OTHER = 2'd0,
        CK_FMT   = 2'd1,
        CK_BEXT  = 2'd2,
        CK_DATA  = 2'd3
    } t_chunk_kind;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_SKIPPED = 3'd4;
    localparam logic [2:0] KIND_IGNORED = 3'd5;

    localparam logic [2:0] ST_PARSING  = 3'd0;
    localparam logic [2:0] ST_NOT_RIFF = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_NOT_WAVE = 3'd3;
    localparam logic [2:0] ST_OVERRUN  = 3'd4;
    localparam logic [2:0] ST_FINISHED = 3'd5;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_BEXT = 32'h7478_6562;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] HEADER_BYTES = 32'd8;
    localparam logic [31:0] FORM_BYTES   = 32'd4;
    localparam logic [2:0]  FIELD_BYTES  = 3'd4;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  field_count;
        logic [31:0] tag_shift;
        logic [31:0] riff_rem;
        logic [31:0] chunk_length;
        logic [31:0] body_rem;
        logic [31:0] offset;
        t_chunk_kind chunk_kind;
        logic [31:0] data_sum;
        logic [2:0]  status;
    } t_state;

    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [31:0] chunk_offset;
        logic [31:0] data_total;
        logic [2:0]  parse_status;
    } t_result;

    localparam t_state C_RESET_STATE = '{
        phase:        PH_RIFF,
        field_count:  3'd0,
        tag_shift:    32'd0,
        riff_rem:     32'd0,
        chunk_length: 32'd0,
        body_rem:     32'd0,
        offset:       32'd0,
        chunk_kind:   CK_OTHER,
        data_sum:     32'd0,
        status:       ST_PARSING
    };

endpackage

FILE: rtl/riff_wave_chunk_walker.sv
// result: each accepted input beat gives its result beat, registered, in the next cycle
// throughput: one byte per cycle while i_ready takes each result, set by the single
// state update between the parser state register and the result register
// reset (i_rst_n low, synchronous): parser back at the riff tag, totals
// cleared, no result held; i_start_of_file restarts the parser in-band
module riff_wave_chunk_walker
    import rwcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_byte_kind,
    output logic [7:0]  o_payload_byte,
    output logic [31:0] o_chunk_offset,
    output logic [31:0] o_data_total,
    output logic [2:0]  o_parse_status
);

    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    t_result    r_result;
    logic [7:0] r_byte;
    logic       r_valid;
    logic       in_fire;

    assign o_ready = !r_valid || i_ready;
    assign in_fire = i_valid && o_ready;

    rwcw_step u_step (
        .i_state         (r_state),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_RESET_STATE;
            r_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
            r_byte   <= i_data_byte;
        end
    end

    assign o_valid        = r_valid;
    assign o_byte_kind    = r_result.byte_kind;
    assign o_payload_byte = r_byte;
    assign o_chunk_offset = r_result.chunk_offset;
    assign o_data_total   = r_result.data_total;
    assign o_parse_status = r_result.parse_status;

    a_err_means_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.status != ST_PARSING |-> r_state.phase == PH_DONE)
        else $error("error status outside done phase");

    a_body_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_BODY |-> r_state.body_rem != 32'd0)
        else $error("chunk body entered with nothing left");

    a_ignored_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_kind == KIND_IGNORED |-> o_parse_status != ST_PARSING)
        else $error("ignored beat while still parsing");

    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_valid)
        else $error("accepted beat produced no result");

endmodule

FILE: rtl/rwcw_step.sv
module rwcw_step
    import rwcw_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_of_file,
    output t_state     o_state,
    output t_result    o_result
);

    always_comb begin
        t_state      cur;
        t_state      nxt;
        t_chunk_kind kind_new;
        logic [2:0]  kind;
        logic [31:0] offset;
        logic [2:0]  fc_inc;
        logic [31:0] tag_new;
        logic [31:0] len_new;
        logic [32:0] padded;
        logic [31:0] rem8;
        logic [31:0] left;
        logic [31:0] body_dec;

        cur      = i_start_of_file ? C_RESET_STATE : i_state;
        nxt      = cur;
        kind     = KIND_IGNORED;
        offset   = 32'd0;
        fc_inc   = cur.field_count + 3'd1;
        tag_new  = {i_data_byte, cur.tag_shift[31:8]};
        len_new  = (cur.field_count < FIELD_BYTES) ? cur.chunk_length
                                                   : {i_data_byte, cur.chunk_length[31:8]};
        padded   = {1'b0, len_new} + {32'd0, len_new[0]};
        rem8     = cur.riff_rem - HEADER_BYTES;
        left     = rem8 - padded[31:0];
        body_dec = cur.body_rem - 32'd1;
        // tag is complete by the last length beat
        if (cur.tag_shift == TAG_FMT) begin
            kind_new = CK_FMT;
        end else if (cur.tag_shift == TAG_BEXT) begin
            kind_new = CK_BEXT;
        end else if (cur.tag_shift == TAG_DATA) begin
            kind_new = CK_DATA;
        end else begin
            kind_new = CK_OTHER;
        end

        case (cur.phase)
            PH_RIFF: begin
                kind             = KIND_HEADER;
                nxt.tag_shift    = tag_new;
                nxt.field_count  = fc_inc;
                if (fc_inc == FIELD_BYTES) begin
                    nxt.field_count = 3'd0;
                    if (tag_new != TAG_RIFF) begin
                        nxt.phase  = PH_DONE;
                        nxt.status = ST_NOT_RIFF;
                    end else begin
                        nxt.phase = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                kind            = KIND_HEADER;
                nxt.riff_rem    = {i_data_byte, cur.riff_rem[31:8]};
                nxt.field_count = fc_inc;
                if (fc_inc == FIELD_BYTES) begin
                    nxt.field_count = 3'd0;
                    if (nxt.riff_rem < FORM_BYTES) begin
                        nxt.phase  = PH_DONE;
                        nxt.status = ST_SHORT;
                    end else begin
                        nxt.riff_rem = nxt.riff_rem - FORM_BYTES;
                        nxt.phase    = PH_WAVE;
                    end
                end
            end
            PH_WAVE: begin
                kind            = KIND_HEADER;
                nxt.tag_shift   = tag_new;
                nxt.field_count = fc_inc;
                if (fc_inc == FIELD_BYTES) begin
                    if (tag_new != TAG_WAVE) begin
                        nxt.phase  = PH_DONE;
                        nxt.status = ST_NOT_WAVE;
                    end else begin
                        nxt.field_count = 3'd0;
                        if (cur.riff_rem >= HEADER_BYTES) begin
                            nxt.phase = PH_HDR;
                        end else begin
                            nxt.phase  = PH_DONE;
                            nxt.status = ST_FINISHED;
                        end
                    end
                end
            end
            PH_HDR: begin
                kind             = KIND_HEADER;
                nxt.field_count  = fc_inc;
                nxt.chunk_length = len_new;
                if (cur.field_count < FIELD_BYTES) begin
                    nxt.tag_shift = tag_new;
                end
                if (fc_inc == 3'd0) begin
                    nxt.riff_rem   = rem8;
                    nxt.chunk_kind = kind_new;
                    if (kind_new == CK_DATA) begin
                        nxt.data_sum = cur.data_sum + len_new;
                    end
                    if (padded > {1'b0, rem8}) begin
                        nxt.phase  = PH_DONE;
                        nxt.status = ST_OVERRUN;
                    end else begin
                        nxt.riff_rem = left;
                        nxt.body_rem = padded[31:0];
                        nxt.offset   = 32'd0;
                        if (padded == 33'd0) begin
                            if (left >= HEADER_BYTES) begin
                                nxt.phase = PH_HDR;
                            end else begin
                                nxt.phase  = PH_DONE;
                                nxt.status = ST_FINISHED;
                            end
                        end else begin
                            nxt.phase = PH_BODY;
                        end
                    end
                end
            end
            PH_BODY: begin
                offset = cur.offset;
                if (cur.offset < cur.chunk_length && cur.chunk_kind != CK_OTHER) begin
                    kind = {1'b0, cur.chunk_kind};
                end else begin
                    kind = KIND_SKIPPED;
                end
                nxt.offset   = cur.offset + 32'd1;
                nxt.body_rem = body_dec;
                if (body_dec == 32'd0) begin
                    nxt.field_count = 3'd0;
                    if (cur.riff_rem >= HEADER_BYTES) begin
                        nxt.phase = PH_HDR;
                    end else begin
                        nxt.phase  = PH_DONE;
                        nxt.status = ST_FINISHED;
                    end
                end
            end
            default: begin
                kind = KIND_IGNORED;
            end
        endcase

        o_state               = nxt;
        o_result.byte_kind    = kind;
        o_result.chunk_offset = offset;
        o_result.data_total   = nxt.data_sum;
        o_result.parse_status = nxt.status;
    end

endmodule

FILE: verif/riff_wave_chunk_walker_tb.sv
module riff_wave_chunk_walker_tb;
    import rwcw_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
        logic       drain;
    } stream_byte_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [31:0] offset;
        logic [31:0] total;
        logic [2:0]  status;
    } byte_verdict_t;

    typedef enum {
        SHAPE_GOOD,
        SHAPE_BAD_RIFF,
        SHAPE_SHORT,
        SHAPE_BAD_WAVE,
        SHAPE_OVERRUN,
        SHAPE_HUGE,
        SHAPE_NOISE
    } file_shape_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_start_of_file = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_byte_kind;
    logic [7:0]  o_payload_byte;
    logic [31:0] o_chunk_offset;
    logic [31:0] o_data_total;
    logic [2:0]  o_parse_status;

    stream_byte_t  file_bytes[$];
    byte_verdict_t expected_verdicts[$];

    int sent = 0;
    int got = 0;
    int gap_left = 0;
    int stall_left = 0;
    int cut_left = 1 << 30;
    int total_bytes = 0;
    int mismatches = 0;
    bit failed = 1'b0;
    logic next_sof = 1'b0;
    logic next_drain = 1'b0;

    // walker state
    t_phase      ph;
    logic [2:0]  fld_cnt;
    logic [31:0] tag_acc;
    logic [31:0] riff_left;
    logic [31:0] chunk_len;
    logic [32:0] body_left;
    t_chunk_kind chunk_type;
    logic [31:0] data_acc;
    logic [2:0]  walk_status;

    riff_wave_chunk_walker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_byte_kind     (o_byte_kind),
        .o_payload_byte  (o_payload_byte),
        .o_chunk_offset  (o_chunk_offset),
        .o_data_total    (o_data_total),
        .o_parse_status  (o_parse_status)
    );

    always #6 i_clk = ~i_clk;

    task automatic clear_walker();
        ph = PH_RIFF;
        fld_cnt = 3'd0;
        tag_acc = 32'd0;
        riff_left = 32'd0;
        chunk_len = 32'd0;
        body_left = 33'd0;
        chunk_type = CK_OTHER;
        data_acc = 32'd0;
        walk_status = ST_PARSING;
    endtask

    task automatic abort_file(input logic [2:0] code);
        ph = PH_DONE;
        walk_status = code;
    endtask

    task automatic advance_chunk();
        fld_cnt = 3'd0;
        if (riff_left >= HEADER_BYTES) begin
            ph = PH_HDR;
        end else begin
            ph = PH_DONE;
            walk_status = ST_FINISHED;
        end
    endtask

    task automatic walk_byte(input logic [7:0] b, input logic sof, output byte_verdict_t r);
        logic [32:0] span;
        logic [32:0] pos;
        logic [2:0]  kind;
        kind = KIND_IGNORED;
        pos = 33'd0;
        if (sof)
            clear_walker();
        case (ph)
            PH_RIFF: begin
                kind = KIND_HEADER;
                tag_acc = {b, tag_acc[31:8]};
                fld_cnt = fld_cnt + 3'd1;
                if (fld_cnt == FIELD_BYTES) begin
                    fld_cnt = 3'd0;
                    if (tag_acc != TAG_RIFF)
                        abort_file(ST_NOT_RIFF);
                    else
                        ph = PH_LEN;
                end
            end
            PH_LEN: begin
                kind = KIND_HEADER;
                riff_left = {b, riff_left[31:8]};
                fld_cnt = fld_cnt + 3'd1;
                if (fld_cnt == FIELD_BYTES) begin
                    fld_cnt = 3'd0;
                    if (riff_left < FORM_BYTES) begin
                        abort_file(ST_SHORT);
                    end else begin
                        riff_left = riff_left - FORM_BYTES;
                        ph = PH_WAVE;
                    end
                end
            end
            PH_WAVE: begin
                kind = KIND_HEADER;
                tag_acc = {b, tag_acc[31:8]};
                fld_cnt = fld_cnt + 3'd1;
                if (fld_cnt == FIELD_BYTES) begin
                    if (tag_acc != TAG_WAVE)
                        abort_file(ST_NOT_WAVE);
                    else
                        advance_chunk();
                end
            end
            PH_HDR: begin
                kind = KIND_HEADER;
                if (fld_cnt < FIELD_BYTES)
                    tag_acc = {b, tag_acc[31:8]};
                else
                    chunk_len = {b, chunk_len[31:8]};
                fld_cnt = fld_cnt + 3'd1;
                if (fld_cnt == 3'd0) begin
                    span = {1'b0, chunk_len} + {32'd0, chunk_len[0]};
                    riff_left = riff_left - HEADER_BYTES;
                    case (tag_acc)
                        TAG_FMT:  chunk_type = CK_FMT;
                        TAG_BEXT: chunk_type = CK_BEXT;
                        TAG_DATA: chunk_type = CK_DATA;
                        default:  chunk_type = CK_OTHER;
                    endcase
                    if (chunk_type == CK_DATA)
                        data_acc = data_acc + chunk_len;
                    if (span > {1'b0, riff_left}) begin
                        abort_file(ST_OVERRUN);
                    end else begin
                        riff_left = riff_left - span[31:0];
                        body_left = span;
                        if (span == 33'd0)
                            advance_chunk();
                        else
                            ph = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                span = {1'b0, chunk_len} + {32'd0, chunk_len[0]};
                pos = span - body_left;
                if (pos < {1'b0, chunk_len} && chunk_type != CK_OTHER)
                    kind = {1'b0, chunk_type};
                else
                    kind = KIND_SKIPPED;
                body_left = body_left - 33'd1;
                if (body_left == 33'd0)
                    advance_chunk();
            end
            default: kind = KIND_IGNORED;
        endcase
        r = '{kind, b, pos[31:0], data_acc, walk_status};
    endtask

    task automatic push_byte(input logic [7:0] b);
        stream_byte_t it;
        if (cut_left == 0)
            return;
        cut_left--;
        it.data = b;
        it.sof = next_sof;
        it.drain = next_drain;
        next_sof = 1'b0;
        next_drain = 1'b0;
        file_bytes.push_back(it);
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            push_byte(w[8*k +: 8]);
    endtask

    task automatic emit_file(input file_shape_t shape);
        logic [31:0] tags [4];
        logic [31:0] lens [4];
        logic [31:0] riff_len;
        logic [31:0] riff_tag;
        logic [31:0] wave_tag;
        int n;
        int extra;
        next_sof = 1'b1;
        if (shape == SHAPE_NOISE) begin
            cut_left = 1 << 30;
            repeat ($urandom_range(1, 24)) begin
                next_sof = ($urandom_range(0, 5) == 0);
                push_byte(8'($urandom_range(0, 255)));
            end
            return;
        end
        cut_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : 1 << 30;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
                0:       tags[k] = TAG_FMT;
                1:       tags[k] = TAG_BEXT;
                2:       tags[k] = TAG_DATA;
                default: tags[k] = $urandom;
            endcase
            lens[k] = $urandom_range(0, 24);
        end
        if (shape == SHAPE_OVERRUN)
            lens[n-1] = $urandom_range(1, 40);
        if (shape == SHAPE_HUGE) begin
            tags[n-1] = TAG_DATA;
            lens[n-1] = 32'hFFFF_FFFF - $urandom_range(0, 1);
        end
        if ((shape == SHAPE_GOOD && $urandom_range(0, 5) == 0) || shape == SHAPE_BAD_RIFF
                || shape == SHAPE_SHORT || shape == SHAPE_BAD_WAVE)
            n = 0;
        riff_len = FORM_BYTES;
        for (int k = 0; k < n; k++)
            riff_len = riff_len + HEADER_BYTES + lens[k] + {31'd0, lens[k][0]};
        extra = $urandom_range(0, 7);
        riff_tag = TAG_RIFF;
        wave_tag = TAG_WAVE;
        case (shape)
            SHAPE_GOOD:     riff_len = riff_len + extra;
            SHAPE_BAD_RIFF: riff_tag = riff_tag ^ (32'd1 << $urandom_range(0, 31));
            SHAPE_SHORT:    riff_len = $urandom_range(0, 3);
            SHAPE_BAD_WAVE: wave_tag = wave_tag ^ (32'd1 << $urandom_range(0, 31));
            SHAPE_OVERRUN:
                riff_len = riff_len - 32'd1
                    - $urandom_range(0, lens[n-1] + {31'd0, lens[n-1][0]} - 32'd1);
            default:        riff_len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
        endcase
        push_word(riff_tag);
        push_word(riff_len);
        push_word(wave_tag);
        for (int k = 0; k < n; k++) begin
            push_word(tags[k]);
            push_word(lens[k]);
            if (shape != SHAPE_GOOD && k == n - 1)
                repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
            else
                repeat (lens[k] + {31'd0, lens[k][0]}) push_byte(8'($urandom_range(0, 255)));
        end
        repeat (extra + $urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
    endtask

    // sender
    always @(posedge i_clk) begin
        stream_byte_t  it;
        byte_verdict_t want;
        logic          v_next;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            v_next = i_valid;
            if (i_valid && o_ready) begin
                walk_byte(i_data_byte, i_start_of_file, want);
                expected_verdicts.push_back(want);
                sent++;
                v_next = 1'b0;
                gap_left = ((sent / 200) % 3 == 2) ? 0 : $urandom_range(0, 19);
            end
            if (!v_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (file_bytes.size() > 0
                        && !(file_bytes[0].drain && expected_verdicts.size() != 0)) begin
                    it = file_bytes.pop_front();
                    i_data_byte <= it.data;
                    i_start_of_file <= it.sof;
                    v_next = 1'b1;
                end
            end
            i_valid <= v_next;
        end
    end

    // receiver
    always @(posedge i_clk) begin
        byte_verdict_t seen;
        byte_verdict_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                seen = '{o_byte_kind, o_payload_byte, o_chunk_offset, o_data_total,
                         o_parse_status};
                got++;
                if (expected_verdicts.size() == 0) begin
                    failed = 1'b1;
                    $display("%0t: result beat with nothing expected, kind %0d byte %02h",
                             $time, seen.kind, seen.value);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (seen !== want) begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 200)
                            $display({"%0t: expected kind %0d byte %02h off %0d total %0d ",
                                      "status %0d, got kind %0d byte %02h off %0d total %0d ",
                                      "status %0d"}, $time,
                                     want.kind, want.value, want.offset, want.total,
                                     want.status, seen.kind, seen.value, seen.offset,
                                     seen.total, seen.status);
                    end
                end
                stall_left = ((got / 170) % 3 == 1) ? 0 : $urandom_range(0, 19);
                // long hold so the block backs up into its input
                if (got == 300 || got == 1200)
                    stall_left = 90;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_ready <= (stall_left == 0);
        end
    end

    initial begin
        int          files;
        int          r;
        file_shape_t shape;
        files = 0;
        clear_walker();
        // shortest legal file, a bad tag, a short length
        next_sof = 1'b1;
        push_word(TAG_RIFF);
        push_word(FORM_BYTES);
        push_word(TAG_WAVE);
        next_sof = 1'b1;
        push_word(TAG_RIFF ^ 32'h0000_2000);
        next_sof = 1'b1;
        push_word(TAG_RIFF);
        push_word($urandom_range(0, 3));
        while (file_bytes.size() < 1900) begin
            files++;
            next_drain = (files % 15 == 14);
            r = $urandom_range(0, 99);
            shape = r < 60 ? SHAPE_GOOD :
                    r < 68 ? SHAPE_OVERRUN :
                    r < 72 ? SHAPE_HUGE :
                    r < 77 ? SHAPE_BAD_RIFF :
                    r < 82 ? SHAPE_SHORT :
                    r < 87 ? SHAPE_BAD_WAVE : SHAPE_NOISE;
            emit_file(shape);
        end
        total_bytes = file_bytes.size();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (sent != total_bytes || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (!failed && expected_verdicts.size() == 0)
            $display("riff_wave_chunk_walker verification clean");
        else
            $display("riff_wave_chunk_walker verification failed");
        $finish;
    end

    initial begin
        #(12 * 600000);
        $display("riff_wave_chunk_walker verification failed");
        $finish;
    end

endmodule
